FILE: design/fmp_pkg.sv
// Package for the Fibonacci-mod-prime block: field widths, modulus,
// reduction constant and the sequencer state type. No dependencies.
package fmp_pkg;

  // Fixed field widths
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned VALUE_W = 30;

  // Modulus and Barrett constant floor(2^61 / FIB_PRIME)
  localparam logic [VALUE_W-1:0] FIB_PRIME  = 30'd1000000007;
  localparam logic [31:0]        BARRETT_MU = 32'd2305842993;

  // Sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_SQ_A    = 10'b00_0000_0010,
    ST_SQ_B    = 10'b00_0000_0100,
    ST_SUM     = 10'b00_0000_1000,
    ST_RED_Q   = 10'b00_0001_0000,
    ST_RED_QP  = 10'b00_0010_0000,
    ST_RED_R   = 10'b00_0100_0000,
    ST_RED_FIX = 10'b00_1000_0000,
    ST_PROD    = 10'b01_0000_0000,
    ST_FIN     = 10'b10_0000_0000
  } fmp_state_e;

endpackage

FILE: design/fibonacci_mod_prime_top.sv
// Fibonacci number modulo 1000000007 by fast doubling on one shared
// 32x32 multiplier with Barrett reduction. Depends on fmp_pkg.
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries index_i (n). Output
//   channel out_valid_o / out_ready_i carries fib_value_o = F(n) mod p,
//   F(0) = 0, F(1) = F(2) = 1. Only the low INDEX_BITS bits of n count.
//   One result per index, in order.
// Sequencing:
//   The block walks INDEX_BITS bits of n, most significant first. Each bit
//   takes two modular products (F(2k+1) = a^2 + b^2 and F(2k) =
//   a(2b - a)), each a multiply and sum followed by a Barrett reduction
//   (two more multiplier passes and a subtract) plus up to two final
//   subtracts. The single multiplier sets the pace, and one index is
//   worked at a time. in_ready_o is high only while the sequencer is idle.
// Reset and stall:
//   rst_ni clears the sequencer and the output valid. A finished result
//   sits in the output register; the next index is accepted meanwhile, and
//   that index waits in its last step until the output register is free.
module fibonacci_mod_prime_top
  import fmp_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [INDEX_W-1:0] index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VALUE_W-1:0] fib_value_o
);

  localparam int unsigned CNT_W = $clog2(INDEX_BITS);

  fmp_state_e              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    phase_q, phase_d;
  logic                    out_valid_q, out_valid_d;

  logic [INDEX_BITS-1:0]   n_q, n_load;
  logic [VALUE_W-1:0]      a_q, b_q, odd_q, b2_q, t_q, out_q;
  logic [59:0]             sq_q;
  logic [60:0]             x_q;
  logic [31:0]             r_q;
  logic [63:0]             mul_q;

  logic [31:0]             mul_a, mul_b;
  logic                    in_xfer;
  logic                    out_free;
  logic                    r_ge_p;
  logic [VALUE_W:0]        b2_sum, t_sum, ab_sum;
  logic [VALUE_W-1:0]      b2_red, t_red, ab_red;
  logic [VALUE_W-1:0]      even_v;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign fib_value_o = out_q;

  // Fit the index into the working width, zero-extend or truncate
  if (INDEX_BITS > INDEX_W) begin : g_idx_ext
    assign n_load = {{(INDEX_BITS-INDEX_W){1'b0}}, index_i};
  end else begin : g_idx_trunc
    assign n_load = index_i[INDEX_BITS-1:0];
  end

  // Small modular helpers: 2b mod p, (2b - a) mod p, (F(2k) + F(2k+1)) mod p
  always_comb begin
    b2_sum = {1'b0, b_q} + {1'b0, b_q};
    b2_red = (b2_sum >= {1'b0, FIB_PRIME}) ? VALUE_W'(b2_sum - {1'b0, FIB_PRIME})
                                           : b2_sum[VALUE_W-1:0];
    t_sum  = (b2_q >= a_q) ? ({1'b0, b2_q} - {1'b0, a_q})
                           : ({1'b0, b2_q} + {1'b0, FIB_PRIME} - {1'b0, a_q});
    t_red  = t_sum[VALUE_W-1:0];
    even_v = r_q[VALUE_W-1:0];
    ab_sum = {1'b0, even_v} + {1'b0, odd_q};
    ab_red = (ab_sum >= {1'b0, FIB_PRIME}) ? VALUE_W'(ab_sum - {1'b0, FIB_PRIME})
                                           : ab_sum[VALUE_W-1:0];
    r_ge_p = (r_q >= {2'b00, FIB_PRIME});
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ_A: begin
        mul_a = {2'b00, a_q};
        mul_b = {2'b00, a_q};
      end
      ST_SQ_B: begin
        mul_a = {2'b00, b_q};
        mul_b = {2'b00, b_q};
      end
      ST_RED_Q: begin
        mul_a = x_q[60:29];
        mul_b = BARRETT_MU;
      end
      ST_RED_QP: begin
        mul_a = mul_q[63:32];
        mul_b = {2'b00, FIB_PRIME};
      end
      ST_PROD: begin
        mul_a = {2'b00, a_q};
        mul_b = {2'b00, t_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer: next state, bit counter, phase, output valid
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cnt_d   = CNT_W'(INDEX_BITS - 1);
          state_d = ST_SQ_A;
        end
      end
      ST_SQ_A: state_d = ST_SQ_B;
      ST_SQ_B: begin
        phase_d = 1'b0;
        state_d = ST_SUM;
      end
      ST_SUM:    state_d = ST_RED_Q;
      ST_RED_Q:  state_d = ST_RED_QP;
      ST_RED_QP: state_d = ST_RED_R;
      ST_RED_R:  state_d = ST_RED_FIX;
      ST_RED_FIX: begin
        if (!r_ge_p) begin
          if (!phase_q) begin
            state_d = ST_PROD;
          end else if (cnt_q == '0) begin
            state_d = ST_FIN;
          end else begin
            cnt_d   = cnt_q - 1'b1;
            state_d = ST_SQ_A;
          end
        end
      end
      ST_PROD: begin
        phase_d = 1'b1;
        state_d = ST_SUM;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          n_q <= n_load;
          a_q <= '0;
          b_q <= VALUE_W'(1);
        end
      end
      ST_SQ_A: b2_q <= b2_red;
      ST_SQ_B: begin
        sq_q <= mul_q[59:0];
        t_q  <= t_red;
      end
      ST_SUM:   x_q <= {1'b0, sq_q} + mul_q[60:0];
      ST_RED_R: r_q <= x_q[31:0] - mul_q[31:0];
      ST_RED_FIX: begin
        if (r_ge_p) begin
          r_q <= r_q - {2'b00, FIB_PRIME};
        end else if (!phase_q) begin
          odd_q <= even_v;
        end else if (n_q[cnt_q]) begin
          // Odd step: (F(2k+1), F(2k+2))
          a_q <= odd_q;
          b_q <= ab_red;
        end else begin
          // Even step: (F(2k), F(2k+1))
          a_q <= even_v;
          b_q <= odd_q;
        end
      end
      ST_PROD: sq_q <= '0;
      ST_FIN: begin
        if (out_free) begin
          out_q <= a_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/fmp_checker.sv
// Port-level checker for fibonacci_mod_prime_top, bound to the top level.
// Depends on fmp_pkg for the modulus.
module fmp_checker
  import fmp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [VALUE_W-1:0] fib_value_o
);

  // Hold a stalled result steady
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fib_value_o))
    else $error("result changed or dropped while stalled");

  // Every result is a residue below the modulus
  a_out_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fib_value_o < FIB_PRIME)
    else $error("result not reduced below modulus");

  // Drop ready for the cycles after an index transfer
  a_busy_after_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input ready while an index is in work");

  // A new result never appears within a few cycles of an index transfer
  a_no_early_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o ##1 !out_valid_o)
    else $error("result shown too early after index transfer");

endmodule

bind fibonacci_mod_prime_top fmp_checker u_fmp_checker (.*);

FILE: sim/fibonacci_mod_prime_top_test.sv
// Testbench for fibonacci_mod_prime_top: directed and random indexes, a
// matrix-power predictor of F(n) mod p, random idling on both channels.
// Depends on fmp_pkg and the design sources.
`timescale 1ns / 1ps

module fibonacci_mod_prime_top_test;
  import fmp_pkg::*;

  localparam logic [63:0] PRIME64 = 64'(FIB_PRIME);
  localparam int unsigned SETTLE_CYCLES = 600;

  typedef struct packed {
    logic [63:0] a, b, c, d;
  } fib_mat_t;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [INDEX_W-1:0] index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VALUE_W-1:0] fib_value;

  logic [INDEX_W-1:0] index_pending[$];
  logic [VALUE_W-1:0] fib_expected[$];
  int unsigned        total_items = 0;
  int unsigned        sent_cnt = 0;
  int unsigned        recv_cnt = 0;
  int unsigned        err_cnt = 0;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;

  fibonacci_mod_prime_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .index_i     (index),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .fib_value_o (fib_value)
  );

  // Free-running clock, 10 ns period
  always #5 clk_i = ~clk_i;

  // 2x2 matrix product, every entry reduced mod p
  function automatic fib_mat_t fib_mat_mul(input fib_mat_t x, input fib_mat_t y);
    fib_mat_t r;
    r.a = (x.a * y.a + x.b * y.c) % PRIME64;
    r.b = (x.a * y.b + x.b * y.d) % PRIME64;
    r.c = (x.c * y.a + x.d * y.c) % PRIME64;
    r.d = (x.c * y.b + x.d * y.d) % PRIME64;
    return r;
  endfunction

  // F(n) mod p: raise [[0,1],[1,1]] to n-1, apply top row to (1,1)
  function automatic logic [VALUE_W-1:0] fib_mod_prime(input logic [INDEX_W-1:0] n);
    fib_mat_t    acc;
    fib_mat_t    base;
    logic [63:0] e;
    logic [63:0] sum;
    acc  = '{a: 64'd1, b: 64'd0, c: 64'd0, d: 64'd1};
    base = '{a: 64'd0, b: 64'd1, c: 64'd1, d: 64'd1};
    if (n == '0) return '0;
    e = 64'(n) - 64'd1;
    for (int i = 0; i < INDEX_W; i++) begin
      if (e[0]) acc = fib_mat_mul(acc, base);
      e = e >> 1;
      base = fib_mat_mul(base, base);
    end
    sum = (acc.a + acc.b) % PRIME64;
    return sum[VALUE_W-1:0];
  endfunction

  // Idle rates per phase, switched by transfer count on each channel
  always_comb begin
    if (sent_cnt < total_items / 3) send_idle_pct = 32;
    else if (sent_cnt < 2 * total_items / 3) send_idle_pct = 86;
    else send_idle_pct = 0;
    if (recv_cnt < total_items / 3) recv_idle_pct = 86;
    else if (recv_cnt < 2 * total_items / 3) recv_idle_pct = 32;
    else recv_idle_pct = 0;
  end

  // Driver: record the expectation on transfer, hold while stalled
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        fib_expected.push_back(fib_mod_prime(index));
        sent_cnt <= sent_cnt + 1;
      end
      if (!(in_valid && !in_ready)) begin
        if (index_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          index    <= index_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        recv_cnt <= recv_cnt + 1;
        if (fib_expected.size() == 0) begin
          $display("%0t: unexpected result fib_value=%0d", $time, fib_value);
          err_cnt <= err_cnt + 1;
        end else if (fib_value !== fib_expected[0]) begin
          $display("%0t: fib_value mismatch expected=%0d actual=%0d",
                   $time, fib_expected[0], fib_value);
          err_cnt <= err_cnt + 1;
          void'(fib_expected.pop_front());
        end else begin
          void'(fib_expected.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus and end of run
  initial begin
    logic [INDEX_W-1:0] n;
    int unsigned        kind;
    // Extremes, small indexes and bit patterns
    index_pending.push_back(32'd0);
    index_pending.push_back(32'd1);
    index_pending.push_back(32'd2);
    index_pending.push_back(32'd3);
    index_pending.push_back(32'd4);
    index_pending.push_back(32'd5);
    index_pending.push_back(32'd10);
    index_pending.push_back(32'd45);
    index_pending.push_back(32'd46);
    index_pending.push_back(32'd47);
    index_pending.push_back(32'hFFFF_FFFF);
    index_pending.push_back(32'hFFFF_FFFE);
    index_pending.push_back(32'h8000_0000);
    index_pending.push_back(32'h8000_0001);
    index_pending.push_back(32'h7FFF_FFFF);
    index_pending.push_back(32'h5555_5555);
    index_pending.push_back(32'hAAAA_AAAA);
    index_pending.push_back(32'd1000000007);
    index_pending.push_back(32'd1000000008);
    index_pending.push_back(32'd2000000016);
    // Random mix: small, full width, near powers of two, random length
    for (int i = 0; i < 400; i++) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        n = $urandom_range(100);
      end else if (kind < 50) begin
        n = $urandom;
      end else if (kind < 70) begin
        n = (32'd1 << $urandom_range(31)) + 32'($urandom_range(2)) - 32'd1;
      end else begin
        n = $urandom >> $urandom_range(31);
      end
      index_pending.push_back(n);
    end
    total_items = index_pending.size();

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    while (index_pending.size() != 0 || in_valid) @(posedge clk_i);
    while (fib_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && fib_expected.size() == 0) begin
      $display("PASS fibonacci_mod_prime_top");
    end else begin
      $display("FAIL fibonacci_mod_prime_top");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("FAIL fibonacci_mod_prime_top");
    $finish;
  end

endmodule
